// ===== design/ccb_pkg.sv =====
package ccb_pkg;

    localparam int unsigned DIM_W   = 11;
    localparam int unsigned POS_W   = 12;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned COORD_W = 10;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_KEY = 3'd6;

    typedef struct packed {
        logic [DIM_W-1:0]   sprite_width;
        logic [DIM_W-1:0]   sprite_height;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [DIM_W-1:0]   canvas_width;
        logic [DIM_W-1:0]   canvas_height;
        logic [COLOR_W-1:0] transparent_key;
    } t_cfg;

    typedef struct packed {
        logic [DIM_W-1:0]   col;
        logic [DIM_W-1:0]   row;
        logic               last;
        logic               opaque;
        logic [COLOR_W-1:0] color;
    } t_item;

    typedef struct packed {
        logic               write_enable;
        logic [COORD_W-1:0] canvas_x;
        logic [COORD_W-1:0] canvas_y;
        logic [COLOR_W-1:0] color_out;
        logic               last_pixel;
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [DIM_W-1:0]   box_width;
        logic [DIM_W-1:0]   box_height;
    } t_result;

endpackage

// ===== design/clipped_colorkey_blit_bbox.sv =====
// Colour-keyed sprite blitter with canvas clipping and an opaque bounding box. Sprite pixels
// arrive in raster order through a queue-style port and one result leaves for each pixel, in
// order, through a second queue-style port. The sustained rate is one pixel per clock while
// results are popped as they appear. The classifying front end and the blit back end are both
// combinational; a pixel is registered in the two-entry queue between them, and its result is
// registered in a second two-entry queue, where finished results wait, before it reaches the
// output. Configuration registers are written through a simple write port and take effect at
// once; they should only be changed while no pixel is in flight. The box fields are reported
// on the last pixel of each sprite and are zero for a fully transparent sprite.
module clipped_colorkey_blit_bbox #(
    parameter int unsigned MAX_SPRITE_DIM = 1024,
    parameter int unsigned MAX_CANVAS_DIM = 1024,
    parameter int unsigned COLOR_BITS     = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ccb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ccb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [ccb_pkg::COLOR_W-1:0]       i_pixel_color,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_write_enable,
    output logic [ccb_pkg::COORD_W-1:0]       o_canvas_x,
    output logic [ccb_pkg::COORD_W-1:0]       o_canvas_y,
    output logic [ccb_pkg::COLOR_W-1:0]       o_color_out,
    output logic                              o_last_pixel,
    output logic [ccb_pkg::COORD_W-1:0]       o_box_x,
    output logic [ccb_pkg::COORD_W-1:0]       o_box_y,
    output logic [ccb_pkg::DIM_W-1:0]         o_box_width,
    output logic [ccb_pkg::DIM_W-1:0]         o_box_height
);
    import ccb_pkg::*;

    t_cfg    r_cfg;
    t_item   front_item, mid_item;
    t_result back_result, out_result;
    logic    front_push, mid_full, mid_empty, back_pop, back_push, out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sprite_width    <= DIM_W'(16);
            r_cfg.sprite_height   <= DIM_W'(16);
            r_cfg.pos_x           <= '0;
            r_cfg.pos_y           <= '0;
            r_cfg.canvas_width    <= DIM_W'(1024);
            r_cfg.canvas_height   <= DIM_W'(1024);
            r_cfg.transparent_key <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPRITE_WIDTH:    r_cfg.sprite_width    <= i_cfg_data[DIM_W-1:0];
                CFG_SPRITE_HEIGHT:   r_cfg.sprite_height   <= i_cfg_data[DIM_W-1:0];
                CFG_POS_X:           r_cfg.pos_x           <= i_cfg_data[POS_W-1:0];
                CFG_POS_Y:           r_cfg.pos_y           <= i_cfg_data[POS_W-1:0];
                CFG_CANVAS_WIDTH:    r_cfg.canvas_width    <= i_cfg_data[DIM_W-1:0];
                CFG_CANVAS_HEIGHT:   r_cfg.canvas_height   <= i_cfg_data[DIM_W-1:0];
                CFG_TRANSPARENT_KEY: r_cfg.transparent_key <= i_cfg_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ccb_front #(
        .MAX_SPRITE_DIM (MAX_SPRITE_DIM),
        .COLOR_BITS     (COLOR_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .i_pixel_color (i_pixel_color),
        .i_full        (mid_full),
        .o_push        (front_push),
        .o_item        (front_item)
    );

    ccb_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (2)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_item),
        .o_full  (mid_full),
        .i_pop   (back_pop),
        .o_data  (mid_item),
        .o_empty (mid_empty)
    );

    ccb_back #(
        .MAX_CANVAS_DIM (MAX_CANVAS_DIM)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (mid_empty),
        .i_item   (mid_item),
        .o_pop    (back_pop),
        .i_full   (out_full),
        .o_push   (back_push),
        .o_result (back_result)
    );

    ccb_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_result),
        .o_empty (empty)
    );

    assign full           = mid_full;
    assign o_write_enable = out_result.write_enable;
    assign o_canvas_x     = out_result.canvas_x;
    assign o_canvas_y     = out_result.canvas_y;
    assign o_color_out    = out_result.color_out;
    assign o_last_pixel   = out_result.last_pixel;
    assign o_box_x        = out_result.box_x;
    assign o_box_y        = out_result.box_y;
    assign o_box_width    = out_result.box_width;
    assign o_box_height   = out_result.box_height;

endmodule

// ===== design/ccb_fifo.sv =====
module ccb_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("queue occupancy beyond its depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == CNT_FULL) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with occupancy");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !pop_ok) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue transfer in not counted");

endmodule

// ===== design/ccb_front.sv =====
module ccb_front #(
    parameter int unsigned MAX_SPRITE_DIM = 1024,
    parameter int unsigned COLOR_BITS     = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ccb_pkg::t_cfg                       i_cfg,
    input  logic                                i_push,
    input  logic [ccb_pkg::COLOR_W-1:0]         i_pixel_color,
    input  logic                                i_full,
    output logic                                o_push,
    output ccb_pkg::t_item                      o_item
);
    import ccb_pkg::*;

    localparam int unsigned SPR_LIM_I = (MAX_SPRITE_DIM < 2047) ? MAX_SPRITE_DIM : 2047;
    localparam logic [DIM_W-1:0] SPR_LIM = DIM_W'(SPR_LIM_I);
    localparam int unsigned CNT_W = $clog2(SPR_LIM_I);
    localparam logic [COLOR_W-1:0] COLOR_MASK =
        (COLOR_BITS >= COLOR_W) ? {COLOR_W{1'b1}} : COLOR_W'((1 << COLOR_BITS) - 1);

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] w_eff, h_eff, w_m1, h_m1;
    logic [DIM_W-1:0] col, row;
    logic             at_row_end, at_last_row, accept;
    logic [COLOR_W-1:0] color;

    always_comb begin
        if (i_cfg.sprite_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (i_cfg.sprite_width > SPR_LIM) begin
            w_eff = SPR_LIM;
        end else begin
            w_eff = i_cfg.sprite_width;
        end
        if (i_cfg.sprite_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (i_cfg.sprite_height > SPR_LIM) begin
            h_eff = SPR_LIM;
        end else begin
            h_eff = i_cfg.sprite_height;
        end
    end

    assign w_m1        = w_eff - 1'b1;
    assign h_m1        = h_eff - 1'b1;
    assign at_row_end  = DIM_W'(r_col) >= w_m1;
    assign at_last_row = DIM_W'(r_row) >= h_m1;
    assign col         = at_row_end ? w_m1 : DIM_W'(r_col);
    assign row         = at_last_row ? h_m1 : DIM_W'(r_row);
    assign color       = i_pixel_color & COLOR_MASK;
    assign accept      = i_push && !i_full;

    assign o_push        = accept;
    assign o_item.col    = col;
    assign o_item.row    = row;
    assign o_item.last   = at_row_end && at_last_row;
    assign o_item.opaque = color != (i_cfg.transparent_key & COLOR_MASK);
    assign o_item.color  = color;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (at_row_end && at_last_row) begin
                n_col = '0;
                n_row = '0;
            end else if (at_row_end) begin
                n_col = '0;
                n_row = CNT_W'(row + 1'b1);
            end else begin
                n_col = CNT_W'(col + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && o_item.last) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap after the final pixel");

    a_pos_in_sprite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (col <= w_m1) && (row <= h_m1))
        else $error("pixel position outside the sprite");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && at_row_end && !at_last_row) |=> (r_col == '0))
        else $error("column counter did not wrap at the row end");

endmodule

// ===== design/ccb_back.sv =====
module ccb_back #(
    parameter int unsigned MAX_CANVAS_DIM = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ccb_pkg::t_cfg      i_cfg,
    input  logic               i_empty,
    input  ccb_pkg::t_item     i_item,
    output logic               o_pop,
    input  logic               i_full,
    output logic               o_push,
    output ccb_pkg::t_result   o_result
);
    import ccb_pkg::*;

    localparam logic [DIM_W-1:0] CAN_LIM =
        DIM_W'((MAX_CANVAS_DIM < 2047) ? MAX_CANVAS_DIM : 2047);

    logic [DIM_W-1:0] r_min_col, n_min_col;
    logic [DIM_W-1:0] r_max_col, n_max_col;
    logic [DIM_W-1:0] r_min_row, n_min_row;
    logic [DIM_W-1:0] r_max_row, n_max_row;
    logic             r_seen, n_seen;
    logic [DIM_W-1:0] b_min_col, b_max_col, b_min_row, b_max_row;
    logic             b_seen;
    logic [DIM_W-1:0] cw, ch;
    logic [POS_W:0]   cx, cy;
    logic             in_canvas, we, take;

    assign take   = !i_empty && !i_full;
    assign o_pop  = take;
    assign o_push = take;

    assign cw = (i_cfg.canvas_width > CAN_LIM) ? CAN_LIM : i_cfg.canvas_width;
    assign ch = (i_cfg.canvas_height > CAN_LIM) ? CAN_LIM : i_cfg.canvas_height;
    assign cx = {i_cfg.pos_x[POS_W-1], i_cfg.pos_x} + {2'b00, i_item.col};
    assign cy = {i_cfg.pos_y[POS_W-1], i_cfg.pos_y} + {2'b00, i_item.row};
    assign in_canvas = !cx[POS_W] && !cy[POS_W] &&
                       (cx[POS_W-1:0] < {1'b0, cw}) && (cy[POS_W-1:0] < {1'b0, ch});
    assign we = i_item.opaque && in_canvas;

    // The box includes the current pixel before it is reported.
    always_comb begin
        b_min_col = r_min_col;
        b_max_col = r_max_col;
        b_min_row = r_min_row;
        b_max_row = r_max_row;
        b_seen    = r_seen;
        if (i_item.opaque) begin
            b_seen = 1'b1;
            if (!r_seen) begin
                b_min_col = i_item.col;
                b_max_col = i_item.col;
                b_min_row = i_item.row;
                b_max_row = i_item.row;
            end else begin
                if (i_item.col < r_min_col) begin
                    b_min_col = i_item.col;
                end
                if (i_item.col > r_max_col) begin
                    b_max_col = i_item.col;
                end
                if (i_item.row < r_min_row) begin
                    b_min_row = i_item.row;
                end
                if (i_item.row > r_max_row) begin
                    b_max_row = i_item.row;
                end
            end
        end
    end

    always_comb begin
        o_result              = '0;
        o_result.write_enable = we;
        o_result.last_pixel   = i_item.last;
        if (we) begin
            o_result.canvas_x  = cx[COORD_W-1:0];
            o_result.canvas_y  = cy[COORD_W-1:0];
            o_result.color_out = i_item.color;
        end
        if (i_item.last && b_seen) begin
            o_result.box_x      = b_min_col[COORD_W-1:0];
            o_result.box_y      = b_min_row[COORD_W-1:0];
            o_result.box_width  = b_max_col - b_min_col + 1'b1;
            o_result.box_height = b_max_row - b_min_row + 1'b1;
        end
    end

    always_comb begin
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_seen    = r_seen;
        if (take) begin
            if (i_item.last) begin
                n_min_col = '0;
                n_max_col = '0;
                n_min_row = '0;
                n_max_row = '0;
                n_seen    = 1'b0;
            end else begin
                n_min_col = b_min_col;
                n_max_col = b_max_col;
                n_min_row = b_min_row;
                n_max_row = b_max_row;
                n_seen    = b_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_col <= '0;
            r_max_col <= '0;
            r_min_row <= '0;
            r_max_row <= '0;
            r_seen    <= 1'b0;
        end else begin
            r_min_col <= n_min_col;
            r_max_col <= n_max_col;
            r_min_row <= n_min_row;
            r_max_row <= n_max_row;
            r_seen    <= n_seen;
        end
    end

    a_tracker_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_item.last) |=> (!r_seen && r_min_col == '0 && r_max_row == '0))
        else $error("box tracker not cleared after the final pixel");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_min_col <= r_max_col && r_min_row <= r_max_row))
        else $error("box edges out of order");

    a_no_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !we) |-> (o_result.canvas_x == '0 && o_result.color_out == '0))
        else $error("write fields set without a write");

    a_box_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_item.last) |-> (o_result.box_width == '0 && o_result.box_height == '0))
        else $error("box reported before the final pixel");

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ccb_pkg::*;

    localparam int SPRITE_MAX = 1024;
    localparam int CANVAS_MAX = 1024;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 390;
    localparam int CALM_TAIL = 80;
    localparam int LINE_PIXELS = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [COLOR_W-1:0]    color;
        bit                    typed;
        t_result               want;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push = 1'b0;
    logic [COLOR_W-1:0]    i_pixel_color = '0;
    logic                  pop = 1'b0;
    logic                  full;
    logic                  empty;
    logic                  o_write_enable;
    logic [COORD_W-1:0]    o_canvas_x;
    logic [COORD_W-1:0]    o_canvas_y;
    logic [COLOR_W-1:0]    o_color_out;
    logic                  o_last_pixel;
    logic [COORD_W-1:0]    o_box_x;
    logic [COORD_W-1:0]    o_box_y;
    logic [DIM_W-1:0]      o_box_width;
    logic [DIM_W-1:0]      o_box_height;

    clipped_colorkey_blit_bbox #(
        .MAX_SPRITE_DIM(SPRITE_MAX),
        .MAX_CANVAS_DIM(CANVAS_MAX),
        .COLOR_BITS(COLOR_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .push(push),
        .full(full),
        .i_pixel_color(i_pixel_color),
        .empty(empty),
        .pop(pop),
        .o_write_enable(o_write_enable),
        .o_canvas_x(o_canvas_x),
        .o_canvas_y(o_canvas_y),
        .o_color_out(o_color_out),
        .o_last_pixel(o_last_pixel),
        .o_box_x(o_box_x),
        .o_box_y(o_box_y),
        .o_box_width(o_box_width),
        .o_box_height(o_box_height)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [DIM_W-1:0]        spr_w = 16;
    logic [DIM_W-1:0]        spr_h = 16;
    logic signed [POS_W-1:0] org_x = '0;
    logic signed [POS_W-1:0] org_y = '0;
    logic [DIM_W-1:0]        cnv_w = 1024;
    logic [DIM_W-1:0]        cnv_h = 1024;
    logic [COLOR_W-1:0]      key = '0;
    int                      col_cnt = 0;
    int                      row_cnt = 0;
    int                      box_l = 0;
    int                      box_r = 0;
    int                      box_t = 0;
    int                      box_b = 0;
    bit                      opaque_seen = 1'b0;

    t_result pending_results[$];
    t_step   script[$];
    int      mismatch_count = 0;
    bit      idling = 1'b1;

    function automatic int sprite_dim(logic [DIM_W-1:0] v);
        if (v == 0) begin
            return 1;
        end
        return (v > SPRITE_MAX) ? SPRITE_MAX : int'(v);
    endfunction

    function automatic t_result blit_pixel(logic [COLOR_W-1:0] color);
        int      w, h, cw, ch, col, row, cx, cy;
        bit      row_end, last, opaque, we;
        t_result r;
        w = sprite_dim(spr_w);
        h = sprite_dim(spr_h);
        cw = (cnv_w > CANVAS_MAX) ? CANVAS_MAX : int'(cnv_w);
        ch = (cnv_h > CANVAS_MAX) ? CANVAS_MAX : int'(cnv_h);
        col = (col_cnt >= w - 1) ? w - 1 : col_cnt;
        row = (row_cnt >= h - 1) ? h - 1 : row_cnt;
        row_end = col_cnt >= w - 1;
        last = row_end && row_cnt >= h - 1;
        opaque = color != key;
        cx = int'(org_x) + col;
        cy = int'(org_y) + row;
        we = opaque && cx >= 0 && cy >= 0 && cx < cw && cy < ch;
        if (opaque) begin
            if (!opaque_seen) begin
                box_l = col;
                box_r = col;
                box_t = row;
                box_b = row;
                opaque_seen = 1'b1;
            end else begin
                if (col < box_l) box_l = col;
                if (col > box_r) box_r = col;
                if (row < box_t) box_t = row;
                if (row > box_b) box_b = row;
            end
        end
        r = '0;
        if (we) begin
            r.write_enable = 1'b1;
            r.canvas_x = COORD_W'(cx);
            r.canvas_y = COORD_W'(cy);
            r.color_out = color;
        end
        if (last) begin
            r.last_pixel = 1'b1;
            if (opaque_seen) begin
                r.box_x = COORD_W'(box_l);
                r.box_y = COORD_W'(box_t);
                r.box_width = DIM_W'(box_r - box_l + 1);
                r.box_height = DIM_W'(box_b - box_t + 1);
            end
            opaque_seen = 1'b0;
            box_l = 0;
            box_r = 0;
            box_t = 0;
            box_b = 0;
            col_cnt = 0;
            row_cnt = 0;
        end else if (row_end) begin
            col_cnt = 0;
            row_cnt = row + 1;
        end else begin
            col_cnt = col + 1;
        end
        return r;
    endfunction

    function automatic string describe(t_result r);
        return $sformatf("we=%0d x=%0d y=%0d colour=%02h last=%0d box=(%0d,%0d %0dx%0d)",
                         r.write_enable, r.canvas_x, r.canvas_y, r.color_out, r.last_pixel,
                         r.box_x, r.box_y, r.box_width, r.box_height);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_step s;
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.data = data;
        s.color = '0;
        s.typed = 1'b0;
        s.want = '0;
        script.push_back(s);
    endfunction

    function automatic void add_pix(logic [COLOR_W-1:0] color, bit typed, t_result want);
        t_step s;
        s.is_cfg = 1'b0;
        s.idx = '0;
        s.data = '0;
        s.color = color;
        s.typed = typed;
        s.want = want;
        script.push_back(s);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_size(int typical_max);
        int v;
        case ($urandom_range(0, 19))
            0: v = 0;
            1: v = $urandom_range(0, 1) ? SPRITE_MAX : 2047;
            2, 3: v = $urandom_range(typical_max + 1, 40);
            default: v = $urandom_range(1, typical_max);
        endcase
        return {1'($urandom_range(0, 1)), DIM_W'(v)};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_canvas();
        int v;
        case ($urandom_range(0, 19))
            0: v = 0;
            1, 2: v = CANVAS_MAX;
            3, 4: v = $urandom_range(CANVAS_MAX + 1, 2047);
            5, 6, 7: v = $urandom_range(25, CANVAS_MAX - 1);
            default: v = $urandom_range(1, 24);
        endcase
        return {1'($urandom_range(0, 1)), DIM_W'(v)};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_offset(logic [DIM_W-1:0] extent);
        int v;
        case ($urandom_range(0, 19))
            0: v = -2048;
            1: v = 2047;
            2: v = $urandom_range(0, 4095);
            3, 4: v = int'(extent) - $urandom_range(1, 4);
            default: v = $urandom_range(0, 31) - 8;
        endcase
        return POS_W'(v);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SPRITE_WIDTH: spr_w = data[DIM_W-1:0];
            CFG_SPRITE_HEIGHT: spr_h = data[DIM_W-1:0];
            CFG_POS_X: org_x = data[POS_W-1:0];
            CFG_POS_Y: org_y = data[POS_W-1:0];
            CFG_CANVAS_WIDTH: cnv_w = data[DIM_W-1:0];
            CFG_CANVAS_HEIGHT: cnv_h = data[DIM_W-1:0];
            CFG_TRANSPARENT_KEY: key = data[COLOR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [COLOR_W-1:0] color, bit typed, t_result want);
        int gap;
        if (idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_pixel_color <= color;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (typed) begin
            void'(blit_pixel(color));
            pending_results.push_back(want);
        end else begin
            pending_results.push_back(blit_pixel(color));
        end
    endtask

    initial begin
        int stall;
        stall = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall == 0 && idling && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 3);
            end
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && pop && !empty) begin
            got = {o_write_enable, o_canvas_x, o_canvas_y, o_color_out, o_last_pixel,
                   o_box_x, o_box_y, o_box_width, o_box_height};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected transfer: %s", describe(got));
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at %0t: expected %s", $realtime, describe(want));
                        $display("                    actual   %s", describe(got));
                    end
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        t_result            none;
        t_result            drawn;
        logic [COLOR_W-1:0] color;
        int                 random_items;
        int                 n;
        none = '0;
        drawn = '0;
        drawn.write_enable = 1'b1;
        drawn.canvas_x = 1;
        drawn.color_out = 8'hFF;

        // Reset settings: a 16 by 16 sprite at the origin with black as the key.
        add_pix(8'h00, 1'b1, none);
        add_pix(8'hFF, 1'b1, drawn);
        add_cfg(CFG_NONE, 12'hFFF);
        add_cfg(CFG_SPRITE_WIDTH, 12'd3);
        add_cfg(CFG_SPRITE_HEIGHT, 12'd2);
        add_cfg(CFG_POS_X, 12'hFFF);
        add_cfg(CFG_POS_Y, 12'd0);
        add_cfg(CFG_CANVAS_WIDTH, 12'd2047);
        add_cfg(CFG_CANVAS_HEIGHT, 12'd1024);
        add_cfg(CFG_TRANSPARENT_KEY, 12'h0FF);
        add_pix(8'h00, 1'b0, none);
        add_pix(8'hFF, 1'b0, none);
        add_pix(8'h55, 1'b0, none);
        add_pix(8'hAA, 1'b0, none);
        add_pix(8'hFF, 1'b0, none);
        add_pix(8'h01, 1'b0, none);
        add_pix(8'hFE, 1'b0, none);
        // Zero sizes count as one pixel; an empty canvas clips everything.
        add_cfg(CFG_SPRITE_WIDTH, 12'd0);
        add_cfg(CFG_SPRITE_HEIGHT, 12'd0);
        add_cfg(CFG_POS_X, 12'h7FF);
        add_cfg(CFG_POS_Y, 12'h800);
        add_cfg(CFG_CANVAS_WIDTH, 12'd0);
        add_cfg(CFG_CANVAS_HEIGHT, 12'd0);
        add_cfg(CFG_TRANSPARENT_KEY, 12'h000);
        add_pix(8'h00, 1'b0, none);
        add_pix(8'h80, 1'b0, none);
        add_pix(8'h7F, 1'b0, none);
        add_pix(8'h00, 1'b0, none);
        // Sprite touching the far corner of the canvas, then a fully transparent one.
        add_cfg(CFG_SPRITE_WIDTH, 12'd4);
        add_cfg(CFG_SPRITE_HEIGHT, 12'd1);
        add_cfg(CFG_POS_X, 12'd1020);
        add_cfg(CFG_POS_Y, 12'd1023);
        add_cfg(CFG_CANVAS_WIDTH, 12'd1024);
        add_cfg(CFG_CANVAS_HEIGHT, 12'd1024);
        add_cfg(CFG_TRANSPARENT_KEY, 12'h05A);
        add_pix(8'h5A, 1'b0, none);
        add_pix(8'hA5, 1'b0, none);
        add_pix(8'h5A, 1'b0, none);
        add_pix(8'hFF, 1'b0, none);
        add_pix(8'h5A, 1'b0, none);
        add_pix(8'h5A, 1'b0, none);
        add_pix(8'h5A, 1'b0, none);
        add_pix(8'h5A, 1'b0, none);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < script.size(); i++) begin
            if (script[i].is_cfg) begin
                if (i == 0 || !script[i-1].is_cfg) begin
                    settle();
                end
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_pixel(script[i].color, script[i].typed, script[i].want);
            end
        end

        // A single-row sprite, then a single-column sprite, each opaque at both ends
        // so the box spans the whole sprite.
        for (int pass = 0; pass < 2; pass++) begin
            settle();
            write_reg(CFG_SPRITE_WIDTH, (pass == 0) ? 12'(LINE_PIXELS) : 12'd1);
            write_reg(CFG_SPRITE_HEIGHT, (pass == 0) ? 12'd1 : 12'(LINE_PIXELS));
            write_reg(CFG_POS_X, 12'd0);
            write_reg(CFG_POS_Y, 12'd0);
            write_reg(CFG_CANVAS_WIDTH, 12'd1024);
            write_reg(CFG_CANVAS_HEIGHT, 12'd1024);
            write_reg(CFG_TRANSPARENT_KEY, 12'(8'($urandom_range(0, 255))));
            while (col_cnt != 0 || row_cnt != 0) begin
                send_pixel(key, 1'b0, none);
            end
            for (int k = 0; k < LINE_PIXELS; k++) begin
                if (k == 0 || k == LINE_PIXELS - 1) begin
                    color = key ^ 8'($urandom_range(1, 255));
                end else begin
                    color = $urandom_range(0, 1) ? key : 8'($urandom_range(0, 255));
                end
                send_pixel(color, 1'b0, none);
            end
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle();
            write_reg(CFG_SPRITE_WIDTH, random_size(8));
            write_reg(CFG_SPRITE_HEIGHT, random_size(6));
            write_reg(CFG_CANVAS_WIDTH, random_canvas());
            write_reg(CFG_CANVAS_HEIGHT, random_canvas());
            write_reg(CFG_POS_X, random_offset(cnv_w));
            write_reg(CFG_POS_Y, random_offset(cnv_h));
            write_reg(CFG_TRANSPARENT_KEY, 12'($urandom_range(0, 4095)));
            n = $urandom_range(20, 60);
            repeat (n) begin
                idling = random_items < RANDOM_ITEMS - CALM_TAIL;
                color = ($urandom_range(0, 2) == 0) ? key : 8'($urandom_range(0, 255));
                send_pixel(color, 1'b0, none);
                random_items++;
            end
        end

        settle();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
